### rtl/core/ffck_pkg.sv
// Shared types, constants and the key hit-test table for the calculator keypad core.
package ffck_pkg;

	// Latched operator codes as reported on pending_op
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	// Key codes: digits carry their own value
	typedef enum logic [4:0] {
		KEY_0    = 5'd0,
		KEY_1    = 5'd1,
		KEY_2    = 5'd2,
		KEY_3    = 5'd3,
		KEY_4    = 5'd4,
		KEY_5    = 5'd5,
		KEY_6    = 5'd6,
		KEY_7    = 5'd7,
		KEY_8    = 5'd8,
		KEY_9    = 5'd9,
		KEY_ADD  = 5'd10,
		KEY_SUB  = 5'd11,
		KEY_MUL  = 5'd12,
		KEY_DIV  = 5'd13,
		KEY_EQ   = 5'd14,
		KEY_CLR  = 5'd15,
		KEY_ALL  = 5'd16,
		KEY_DEL  = 5'd17,
		KEY_MISS = 5'd31
	} key_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIT,
		ST_EXEC,
		ST_MUL10,
		ST_APPEND,
		ST_WAIT,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		ALU_IDLE,
		ALU_PREP,
		ALU_RUN,
		ALU_FIX
	} alu_phase_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} alu_req_t;

	// Configuration register indexes
	localparam logic CFG_WINDOW_X = 1'b0;
	localparam logic CFG_WINDOW_Y = 1'b1;

	localparam logic signed [31:0] DIGIT_LIMIT     = 32'sd100000000;
	localparam logic signed [31:0] NEG_DIGIT_LIMIT = -32'sd100000000;
	localparam logic [31:0]        DIV_TEN         = 32'd10;
	localparam int                 ALU_STEPS       = 32;

	// Button geometry, window-relative
	localparam logic signed [12:0] KEY_W  = 13'sd50;
	localparam logic signed [12:0] KEY_H  = 13'sd35;
	localparam logic signed [12:0] WIDE_W = 13'sd105;
	localparam logic signed [12:0] COL0_X = 13'sd10;
	localparam logic signed [12:0] COL1_X = 13'sd65;
	localparam logic signed [12:0] COL2_X = 13'sd120;
	localparam logic signed [12:0] COL3_X = 13'sd175;
	localparam logic signed [12:0] ROW0_Y = 13'sd80;
	localparam logic signed [12:0] ROW1_Y = 13'sd120;
	localparam logic signed [12:0] ROW2_Y = 13'sd160;
	localparam logic signed [12:0] ROW3_Y = 13'sd200;
	localparam logic signed [12:0] ROW4_Y = 13'sd240;

	function automatic logic span(input logic signed [12:0] v, input logic signed [12:0] lo,
			input logic signed [12:0] len);
		return (v >= lo) && (v < lo + len);
	endfunction

	// Map a window-relative position to the key under it; rectangles never overlap
	function automatic key_t key_lookup(input logic signed [12:0] rx,
			input logic signed [12:0] ry);
		logic [3:0] col;
		logic [4:0] row;
		logic       wide_l;
		logic       wide_r;
		key_t       k;
		col[0] = span(rx, COL0_X, KEY_W);
		col[1] = span(rx, COL1_X, KEY_W);
		col[2] = span(rx, COL2_X, KEY_W);
		col[3] = span(rx, COL3_X, KEY_W);
		row[0] = span(ry, ROW0_Y, KEY_H);
		row[1] = span(ry, ROW1_Y, KEY_H);
		row[2] = span(ry, ROW2_Y, KEY_H);
		row[3] = span(ry, ROW3_Y, KEY_H);
		row[4] = span(ry, ROW4_Y, KEY_H);
		wide_l = span(rx, COL0_X, WIDE_W);
		wide_r = span(rx, COL2_X, WIDE_W);
		k = KEY_MISS;
		if (row[0]) begin
			if (col[0]) k = KEY_7;
			else if (col[1]) k = KEY_8;
			else if (col[2]) k = KEY_9;
			else if (col[3]) k = KEY_DIV;
		end else if (row[1]) begin
			if (col[0]) k = KEY_4;
			else if (col[1]) k = KEY_5;
			else if (col[2]) k = KEY_6;
			else if (col[3]) k = KEY_MUL;
		end else if (row[2]) begin
			if (col[0]) k = KEY_1;
			else if (col[1]) k = KEY_2;
			else if (col[2]) k = KEY_3;
			else if (col[3]) k = KEY_SUB;
		end else if (row[3]) begin
			if (col[0]) k = KEY_0;
			else if (col[1]) k = KEY_CLR;
			else if (col[2]) k = KEY_EQ;
			else if (col[3]) k = KEY_ADD;
		end else if (row[4]) begin
			if (wide_l) k = KEY_ALL;
			else if (wide_r) k = KEY_DEL;
		end
		return k;
	endfunction

endpackage

### rtl/core/ffck_alu.sv
// Radix-2 iterative multiply and signed truncating divide unit, one bit per cycle.
module ffck_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  ffck_pkg::alu_req_t req,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	output logic               done,
	output logic [31:0]        result
);

	ffck_pkg::alu_phase_t phase_q, phase_d;
	logic        is_div_q;
	logic        neg_q;
	logic        zero_q;
	logic [4:0]  cnt_q;
	logic [31:0] acc_q;
	logic [31:0] opa_q;
	logic [31:0] opb_q;
	logic [33:0] diff;

	assign diff = {1'b0, acc_q, opa_q[31]} - {2'b00, opb_q};

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			ffck_pkg::ALU_IDLE: begin
				if (req.start) phase_d = req.is_div ? ffck_pkg::ALU_PREP : ffck_pkg::ALU_RUN;
			end
			ffck_pkg::ALU_PREP: phase_d = ffck_pkg::ALU_RUN;
			ffck_pkg::ALU_RUN: begin
				if (cnt_q == 5'd0) phase_d = ffck_pkg::ALU_FIX;
			end
			ffck_pkg::ALU_FIX: phase_d = ffck_pkg::ALU_IDLE;
			default: phase_d = ffck_pkg::ALU_IDLE;
		endcase
	end

	always_comb begin
		done   = 1'b0;
		result = acc_q;
		case (phase_q)
			ffck_pkg::ALU_FIX: begin
				done = 1'b1;
				if (is_div_q) begin
					if (zero_q) result = 32'd0;
					else if (neg_q) result = 32'd0 - opa_q;
					else result = opa_q;
				end
			end
			default: done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ffck_pkg::ALU_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			ffck_pkg::ALU_IDLE: begin
				if (req.start) begin
					opa_q    <= a;
					opb_q    <= b;
					is_div_q <= req.is_div;
					neg_q    <= a[31] ^ b[31];
					zero_q   <= (b == 32'd0);
					acc_q    <= 32'd0;
					cnt_q    <= 5'(ffck_pkg::ALU_STEPS - 1);
				end
			end
			ffck_pkg::ALU_PREP: begin
				// divide on magnitudes, fix the sign at the end
				if (opa_q[31]) opa_q <= 32'd0 - opa_q;
				if (opb_q[31]) opb_q <= 32'd0 - opb_q;
			end
			ffck_pkg::ALU_RUN: begin
				cnt_q <= cnt_q - 5'd1;
				if (is_div_q) begin
					if (!diff[33]) begin
						acc_q <= diff[31:0];
						opa_q <= {opa_q[30:0], 1'b1};
					end else begin
						acc_q <= {acc_q[30:0], opa_q[31]};
						opa_q <= {opa_q[30:0], 1'b0};
					end
				end else begin
					if (opb_q[0]) acc_q <= acc_q + opa_q;
					opa_q <= {opa_q[30:0], 1'b0};
					opb_q <= {1'b0, opb_q[31:1]};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (phase_q == ffck_pkg::ALU_IDLE))
		else $error("ALU started while busy");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ffck_pkg::ALU_RUN && cnt_q == 5'd0) |=> (phase_q == ffck_pkg::ALU_FIX))
		else $error("ALU run did not finish after last step");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_div_q && zero_q) |-> (result == 32'd0))
		else $error("divide by zero did not give zero");
`endif

endmodule

### rtl/core/four_function_calculator_keypad_core.sv
// A miss or simple key passes through hit test, execute and response; a digit append also takes
// the multiply-by-ten and append states; equals with * or / and Del wait on the multiply/divide unit.
// Throughput: one click in flight; the next click is taken once the previous result is in the
// output register, which holds it until the consumer takes it.
// Reset (async, active low): window origin, display, operand and operator cleared,
// fresh flag set, no result pending.
module four_function_calculator_keypad_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] click_x,
	input  logic [11:0] click_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        key_hit,
	output logic [31:0] shown_value,
	output logic [2:0]  pending_op,
	output logic        entry_fresh,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [11:0] cfg_data
);

	ffck_pkg::state_t   state_q, state_d;
	ffck_pkg::key_t     key_q;
	ffck_pkg::op_t      op_q;
	ffck_pkg::alu_req_t alu_req;

	logic [11:0] window_x_q;
	logic [11:0] window_y_q;
	logic [11:0] click_x_q;
	logic [11:0] click_y_q;
	logic [31:0] display_q;
	logic [31:0] operand_q;
	logic        fresh_q;
	logic [31:0] prod_q;
	logic        out_valid_q;
	logic        key_hit_q;
	logic [31:0] shown_value_q;
	logic [2:0]  pending_op_q;
	logic        entry_fresh_q;

	logic signed [12:0] rel_x;
	logic signed [12:0] rel_y;
	logic        is_digit;
	logic        in_range;
	logic [31:0] digit;
	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic        alu_done;
	logic [31:0] alu_result;
	logic        resp_load;

	assign rel_x    = $signed({1'b0, click_x_q}) - $signed({1'b0, window_x_q});
	assign rel_y    = $signed({1'b0, click_y_q}) - $signed({1'b0, window_y_q});
	assign is_digit = (key_q <= ffck_pkg::KEY_9);
	assign digit    = {27'd0, key_q};
	assign in_range = ($signed(display_q) < ffck_pkg::DIGIT_LIMIT) &&
		($signed(display_q) > ffck_pkg::NEG_DIGIT_LIMIT);

	ffck_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.done   (alu_done),
		.result (alu_result)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffck_pkg::ST_IDLE: begin
				if (in_valid) state_d = ffck_pkg::ST_HIT;
			end
			ffck_pkg::ST_HIT: state_d = ffck_pkg::ST_EXEC;
			ffck_pkg::ST_EXEC: begin
				if (is_digit) begin
					state_d = (!fresh_q && in_range) ? ffck_pkg::ST_MUL10 : ffck_pkg::ST_RESP;
				end else if (key_q == ffck_pkg::KEY_DEL) begin
					state_d = ffck_pkg::ST_WAIT;
				end else if (key_q == ffck_pkg::KEY_EQ &&
						(op_q == ffck_pkg::OP_MUL || op_q == ffck_pkg::OP_DIV)) begin
					state_d = ffck_pkg::ST_WAIT;
				end else begin
					state_d = ffck_pkg::ST_RESP;
				end
			end
			ffck_pkg::ST_MUL10: state_d = ffck_pkg::ST_APPEND;
			ffck_pkg::ST_APPEND: state_d = ffck_pkg::ST_RESP;
			ffck_pkg::ST_WAIT: begin
				if (alu_done) state_d = ffck_pkg::ST_RESP;
			end
			ffck_pkg::ST_RESP: begin
				if (resp_load) state_d = ffck_pkg::ST_IDLE;
			end
			default: state_d = ffck_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready       = 1'b0;
		resp_load      = 1'b0;
		alu_req.start  = 1'b0;
		alu_req.is_div = 1'b1;
		alu_a          = display_q;
		alu_b          = ffck_pkg::DIV_TEN;
		case (state_q)
			ffck_pkg::ST_IDLE: in_ready = 1'b1;
			ffck_pkg::ST_EXEC: begin
				if (key_q == ffck_pkg::KEY_DEL) begin
					alu_req.start = 1'b1;
				end else if (key_q == ffck_pkg::KEY_EQ &&
						(op_q == ffck_pkg::OP_MUL || op_q == ffck_pkg::OP_DIV)) begin
					alu_req.start  = 1'b1;
					alu_req.is_div = (op_q == ffck_pkg::OP_DIV);
					alu_a          = operand_q;
					alu_b          = display_q;
				end
			end
			ffck_pkg::ST_RESP: resp_load = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ffck_pkg::ST_IDLE;
			window_x_q <= 12'd0;
			window_y_q <= 12'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					ffck_pkg::CFG_WINDOW_X: window_x_q <= cfg_data;
					ffck_pkg::CFG_WINDOW_Y: window_y_q <= cfg_data;
					default: window_x_q <= window_x_q;
				endcase
			end
		end
	end

	// click capture and hit test
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			click_x_q <= click_x;
			click_y_q <= click_y;
		end
		if (state_q == ffck_pkg::ST_HIT) key_q <= ffck_pkg::key_lookup(rel_x, rel_y);
		if (state_q == ffck_pkg::ST_MUL10) begin
			prod_q <= {display_q[28:0], 3'b000} + {display_q[30:0], 1'b0};
		end
	end

	// calculator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_q <= 32'd0;
			operand_q <= 32'd0;
			op_q      <= ffck_pkg::OP_NONE;
			fresh_q   <= 1'b1;
		end else begin
			case (state_q)
				ffck_pkg::ST_EXEC: begin
					case (key_q)
						ffck_pkg::KEY_0, ffck_pkg::KEY_1, ffck_pkg::KEY_2, ffck_pkg::KEY_3,
						ffck_pkg::KEY_4, ffck_pkg::KEY_5, ffck_pkg::KEY_6, ffck_pkg::KEY_7,
						ffck_pkg::KEY_8, ffck_pkg::KEY_9: begin
							if (fresh_q) begin
								display_q <= digit;
								fresh_q   <= 1'b0;
							end
						end
						ffck_pkg::KEY_ADD: begin
							operand_q <= display_q;
							op_q      <= ffck_pkg::OP_ADD;
							fresh_q   <= 1'b1;
						end
						ffck_pkg::KEY_SUB: begin
							operand_q <= display_q;
							op_q      <= ffck_pkg::OP_SUB;
							fresh_q   <= 1'b1;
						end
						ffck_pkg::KEY_MUL: begin
							operand_q <= display_q;
							op_q      <= ffck_pkg::OP_MUL;
							fresh_q   <= 1'b1;
						end
						ffck_pkg::KEY_DIV: begin
							operand_q <= display_q;
							op_q      <= ffck_pkg::OP_DIV;
							fresh_q   <= 1'b1;
						end
						ffck_pkg::KEY_EQ: begin
							case (op_q)
								ffck_pkg::OP_ADD: display_q <= operand_q + display_q;
								ffck_pkg::OP_SUB: display_q <= operand_q - display_q;
								default: display_q <= display_q;
							endcase
							op_q    <= ffck_pkg::OP_NONE;
							fresh_q <= 1'b1;
						end
						ffck_pkg::KEY_CLR: begin
							display_q <= 32'd0;
							fresh_q   <= 1'b1;
						end
						ffck_pkg::KEY_ALL: begin
							display_q <= 32'd0;
							operand_q <= 32'd0;
							op_q      <= ffck_pkg::OP_NONE;
							fresh_q   <= 1'b1;
						end
						default: display_q <= display_q;
					endcase
				end
				ffck_pkg::ST_APPEND: begin
					// append on the negative side for a negative display
					display_q <= display_q[31] ? (prod_q - digit) : (prod_q + digit);
				end
				ffck_pkg::ST_WAIT: begin
					if (alu_done) display_q <= alu_result;
				end
				default: display_q <= display_q;
			endcase
		end
	end

	// result register: hold until the consumer takes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			key_hit_q     <= (key_q != ffck_pkg::KEY_MISS);
			shown_value_q <= display_q;
			pending_op_q  <= op_q;
			entry_fresh_q <= fresh_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign key_hit     = key_hit_q;
	assign shown_value = shown_value_q;
	assign pending_op  = pending_op_q;
	assign entry_fresh = entry_fresh_q;

`ifndef ASSERT_OFF
	a_accept_to_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ffck_pkg::ST_HIT))
		else $error("accepted click did not enter hit test");

	a_alu_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffck_pkg::ST_WAIT && alu_done) |=> (state_q == ffck_pkg::ST_RESP))
		else $error("ALU result not followed by response");

	a_resp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		resp_load |=> out_valid_q)
		else $error("result load did not raise out_valid");
`endif

endmodule

### bench/tb_four_function_calculator_keypad_core.sv
// Self-checking bench for the calculator keypad core: click hit-testing and arithmetic.
`timescale 1ns / 100ps

module tb_four_function_calculator_keypad_core;

	localparam int QUIET_LIMIT = 3000;
	localparam logic [31:0] DIGIT_CAP = 32'd100000000;
	localparam logic [31:0] TEN = 32'd10;
	// Largest origin that still keeps every key on screen
	localparam int WIN_X_REACH = 3871;
	localparam int WIN_Y_REACH = 3821;

	typedef struct packed {
		logic          hit;
		logic [31:0]   value;
		ffck_pkg::op_t op;
		logic          fresh;
	} readout_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [11:0] click_x;
	logic [11:0] click_y;
	logic        out_valid;
	logic        out_ready;
	logic        key_hit;
	logic [31:0] shown_value;
	logic [2:0]  pending_op;
	logic        entry_fresh;
	logic        cfg_we;
	logic        cfg_addr;
	logic [11:0] cfg_data;

	// Calculator state as the bench expects it
	logic [11:0]   win_x = '0;
	logic [11:0]   win_y = '0;
	logic [31:0]   calc_display = '0;
	logic [31:0]   calc_operand = '0;
	ffck_pkg::op_t calc_op = ffck_pkg::OP_NONE;
	logic          calc_fresh = 1'b1;

	readout_t readout_q[$];
	int       keys_hit = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       sink_hold_cycles = 0;
	bit       src_stalls = 1'b0;
	bit       sink_stalls = 1'b0;

	four_function_calculator_keypad_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.click_x     (click_x),
		.click_y     (click_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_hit     (key_hit),
		.shown_value (shown_value),
		.pending_op  (pending_op),
		.entry_fresh (entry_fresh),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic ffck_pkg::key_t pad_key(input int row, input int col);
		case (row * 4 + col)
			0: return ffck_pkg::KEY_7;
			1: return ffck_pkg::KEY_8;
			2: return ffck_pkg::KEY_9;
			3: return ffck_pkg::KEY_DIV;
			4: return ffck_pkg::KEY_4;
			5: return ffck_pkg::KEY_5;
			6: return ffck_pkg::KEY_6;
			7: return ffck_pkg::KEY_MUL;
			8: return ffck_pkg::KEY_1;
			9: return ffck_pkg::KEY_2;
			10: return ffck_pkg::KEY_3;
			11: return ffck_pkg::KEY_SUB;
			12: return ffck_pkg::KEY_0;
			13: return ffck_pkg::KEY_CLR;
			14: return ffck_pkg::KEY_EQ;
			15: return ffck_pkg::KEY_ADD;
			default: return ffck_pkg::KEY_MISS;
		endcase
	endfunction

	// Keys sit on a 55 x 40 pitch; the remainder past 50 x 35 is the gap between keys
	function automatic ffck_pkg::key_t locate_key(input logic [11:0] cx, input logic [11:0] cy);
		int rx;
		int ry;
		int row;
		int col;
		rx = int'(cx) - int'(win_x);
		ry = int'(cy) - int'(win_y);
		if (ry >= 240 && ry < 275) begin
			if (rx >= 10 && rx < 115) return ffck_pkg::KEY_ALL;
			if (rx >= 120 && rx < 225) return ffck_pkg::KEY_DEL;
			return ffck_pkg::KEY_MISS;
		end
		if (ry < 80 || rx < 10) return ffck_pkg::KEY_MISS;
		row = (ry - 80) / 40;
		col = (rx - 10) / 55;
		if (row > 3 || col > 3) return ffck_pkg::KEY_MISS;
		if (ry - 80 - row * 40 >= 35 || rx - 10 - col * 55 >= 50) return ffck_pkg::KEY_MISS;
		return pad_key(row, col);
	endfunction

	function automatic logic [31:0] trunc_div(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] q;
		q = (a[31] ? -a : a) / (b[31] ? -b : b);
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	function automatic void latch_operator(input ffck_pkg::op_t op);
		calc_operand = calc_display;
		calc_op = op;
		calc_fresh = 1'b1;
	endfunction

	function automatic readout_t next_readout(input logic [11:0] cx, input logic [11:0] cy);
		ffck_pkg::key_t k;
		logic [31:0]    digit;
		logic [31:0]    mag;
		readout_t       r;
		k = locate_key(cx, cy);
		digit = {27'd0, k};
		mag = calc_display[31] ? -calc_display : calc_display;
		case (k)
			ffck_pkg::KEY_MISS: ;
			ffck_pkg::KEY_ADD: latch_operator(ffck_pkg::OP_ADD);
			ffck_pkg::KEY_SUB: latch_operator(ffck_pkg::OP_SUB);
			ffck_pkg::KEY_MUL: latch_operator(ffck_pkg::OP_MUL);
			ffck_pkg::KEY_DIV: latch_operator(ffck_pkg::OP_DIV);
			ffck_pkg::KEY_EQ: begin
				case (calc_op)
					ffck_pkg::OP_ADD: calc_display = calc_operand + calc_display;
					ffck_pkg::OP_SUB: calc_display = calc_operand - calc_display;
					ffck_pkg::OP_MUL: calc_display = calc_operand * calc_display;
					ffck_pkg::OP_DIV: calc_display = (calc_display == '0) ? '0 :
						trunc_div(calc_operand, calc_display);
					default: ;
				endcase
				calc_op = ffck_pkg::OP_NONE;
				calc_fresh = 1'b1;
			end
			ffck_pkg::KEY_CLR: begin
				calc_display = '0;
				calc_fresh = 1'b1;
			end
			ffck_pkg::KEY_ALL: begin
				calc_display = '0;
				calc_operand = '0;
				calc_op = ffck_pkg::OP_NONE;
				calc_fresh = 1'b1;
			end
			ffck_pkg::KEY_DEL: calc_display = trunc_div(calc_display, TEN);
			default: begin
				if (calc_fresh) begin
					calc_display = digit;
					calc_fresh = 1'b0;
				end else if (mag < DIGIT_CAP) begin
					// negative entries grow away from zero
					calc_display = calc_display[31] ? calc_display * TEN - digit :
						calc_display * TEN + digit;
				end
			end
		endcase
		r.hit = (k != ffck_pkg::KEY_MISS);
		r.value = calc_display;
		r.op = calc_op;
		r.fresh = calc_fresh;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, what, want, got);
		mismatches++;
	endtask

	task automatic check_readout();
		readout_t want;
		if (readout_q.size() == 0) begin
			report_mismatch("unexpected result", '0, shown_value);
			return;
		end
		want = readout_q.pop_front();
		if (key_hit !== want.hit)
			report_mismatch("key_hit", 32'(want.hit), 32'(key_hit));
		if (shown_value !== want.value)
			report_mismatch("shown_value", want.value, shown_value);
		if (pending_op !== want.op)
			report_mismatch("pending_op", 32'(want.op), 32'(pending_op));
		if (entry_fresh !== want.fresh)
			report_mismatch("entry_fresh", 32'(want.fresh), 32'(entry_fresh));
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) check_readout();
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("[four_function_calculator_keypad_core] ERROR");
		$finish;
	end

	// Result side: random stalls, plus one long hold when a test asks for it
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold_cycles - 1) @(negedge clk);
				sink_hold_cycles = 0;
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (random_gap() - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic hold_off(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic send_click(input logic [11:0] cx, input logic [11:0] cy);
		readout_t r;
		if (src_stalls && $urandom_range(0, 3) == 0) hold_off(random_gap());
		@(negedge clk);
		in_valid <= 1'b1;
		click_x <= cx;
		click_y <= cy;
		do @(posedge clk); while (!in_ready);
		r = next_readout(cx, cy);
		readout_q.push_back(r);
		if (r.hit) keys_hit++;
	endtask

	// Drop valid and hold until every beat sent has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (readout_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(input logic index, input logic [11:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == ffck_pkg::CFG_WINDOW_X) win_x = data;
		else win_y = data;
	endtask

	task automatic set_window(input logic [11:0] wx, input logic [11:0] wy);
		write_cfg(ffck_pkg::CFG_WINDOW_X, wx);
		write_cfg(ffck_pkg::CFG_WINDOW_Y, wy);
	endtask

	function automatic int pick_offset(input int span_len);
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 0 : span_len - 1;
		return $urandom_range(0, span_len - 1);
	endfunction

	task automatic press(input ffck_pkg::key_t k);
		int x0;
		int y0;
		int w;
		int ax;
		int ay;
		x0 = 0;
		y0 = 0;
		w = 50;
		if (k == ffck_pkg::KEY_ALL || k == ffck_pkg::KEY_DEL) begin
			x0 = (k == ffck_pkg::KEY_ALL) ? 10 : 120;
			y0 = 240;
			w = 105;
		end else begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					if (pad_key(r, c) == k) begin
						x0 = 10 + 55 * c;
						y0 = 80 + 40 * r;
					end
		end
		ax = x0 + pick_offset(w) + int'(win_x);
		ay = y0 + pick_offset(35) + int'(win_y);
		// key pushed off screen by the origin: click anywhere instead
		if (ax > 4095 || ay > 4095)
			send_click(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
		else
			send_click(12'(ax), 12'(ay));
	endtask

	task automatic key_seq(input string keys);
		byte ch;
		for (int i = 0; i < keys.len(); i++) begin
			ch = keys[i];
			case (ch)
				"+": press(ffck_pkg::KEY_ADD);
				"-": press(ffck_pkg::KEY_SUB);
				"*": press(ffck_pkg::KEY_MUL);
				"/": press(ffck_pkg::KEY_DIV);
				"=": press(ffck_pkg::KEY_EQ);
				"c": press(ffck_pkg::KEY_CLR);
				"a": press(ffck_pkg::KEY_ALL);
				"d": press(ffck_pkg::KEY_DEL);
				default: press(ffck_pkg::key_t'(5'(ch - "0")));
			endcase
		end
	endtask

	task automatic random_operand();
		int n;
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 4);
		repeat (n)
			press(ffck_pkg::key_t'(5'($urandom_range(ffck_pkg::KEY_0, ffck_pkg::KEY_9))));
	endtask

	task automatic random_expression();
		if ($urandom_range(0, 5) == 0) press(ffck_pkg::KEY_ALL);
		random_operand();
		do begin
			press(ffck_pkg::key_t'(5'($urandom_range(ffck_pkg::KEY_ADD, ffck_pkg::KEY_DIV))));
			case ($urandom_range(0, 7))
				0: ;  // reuse the display as the second operand
				1: press(ffck_pkg::KEY_0);
				2: begin
					random_operand();
					press(ffck_pkg::KEY_DEL);
				end
				3: begin
					random_operand();
					press(ffck_pkg::KEY_CLR);
					random_operand();
				end
				default: random_operand();
			endcase
			press(ffck_pkg::KEY_EQ);
			if ($urandom_range(0, 5) == 0) press(ffck_pkg::KEY_DEL);
		end while ($urandom_range(0, 2) == 0);
	endtask

	task automatic random_noise();
		case ($urandom_range(0, 2))
			0: send_click(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
			1: press(ffck_pkg::key_t'(5'($urandom_range(ffck_pkg::KEY_0, ffck_pkg::KEY_DEL))));
			default: send_click(12'(int'(win_x) + $urandom_range(0, 239)),
				12'(int'(win_y) + $urandom_range(60, 290)));
		endcase
	endtask

	task automatic test_key_edges();
		send_click(12'd0, 12'd0);
		send_click(12'd10, 12'd80);
		send_click(12'd59, 12'd114);
		send_click(12'd60, 12'd80);
		send_click(12'd10, 12'd115);
		send_click(12'd114, 12'd274);
		send_click(12'd225, 12'd240);
	endtask

	task automatic test_arith_corners();
		// equals with nothing latched, entry past the digit cap, multiply wrap
		key_seq("=1000000007*99=");
		// negative result, Del toward zero, divide by zero
		key_seq("c-47=d+0=/0=a");
	endtask

	task automatic test_window_extremes();
		wait_drained();
		set_window(12'hFFF, 12'hFFF);
		send_click(12'hFFF, 12'hFFF);
		send_click(12'h000, 12'h000);
		send_click(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
		wait_drained();
		set_window(12'hFFF, 12'h000);
		send_click(12'hFFF, 12'd100);
		wait_drained();
		set_window(12'h000, 12'hFFF);
		send_click(12'd100, 12'hFFF);
		wait_drained();
		set_window(12'd100, 12'd50);
		key_seq("a12+3=");
	endtask

	task automatic test_output_hold_off();
		wait_drained();
		src_stalls = 1'b0;
		sink_hold_cycles = 300;
		key_seq("a12*34=d");
		// sender pauses here until every result is back
		wait_drained();
		key_seq("-5=");
	endtask

	task automatic test_random_traffic();
		int target;
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			case (ph)
				0: set_window(12'd0, 12'd0);
				1: set_window(12'(WIN_X_REACH), 12'(WIN_Y_REACH));
				default: set_window(12'($urandom_range(0, WIN_X_REACH)),
					12'($urandom_range(0, WIN_Y_REACH)));
			endcase
			src_stalls = (ph != 2) && (ph != 3);
			sink_stalls = (ph != 2) && (ph != 4);
			target = keys_hit + 150;
			while (keys_hit < target) begin
				if ($urandom_range(0, 4) != 0) random_expression();
				else random_noise();
			end
		end
	endtask

	task automatic test_final_drain();
		wait_drained();
		repeat (60) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		click_x = '0;
		click_y = '0;
		cfg_we = 1'b0;
		cfg_addr = ffck_pkg::CFG_WINDOW_X;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_key_edges();
		test_arith_corners();
		test_window_extremes();
		test_output_hold_off();
		test_random_traffic();
		test_final_drain();
		if (mismatches == 0)
			$display("[four_function_calculator_keypad_core] OK");
		else
			$display("[four_function_calculator_keypad_core] ERROR");
		$finish;
	end

endmodule
